FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

FILE: rtl/jpdc_pkg.sv
`timescale 1ns / 1ps

package jpdc_pkg;

    // Grid geometry
    localparam int GRID_W    = 64;
    localparam int GRID_H    = 64;
    localparam int POS_W     = 6;
    localparam int ADDR_W    = 2 + 2 * POS_W;
    localparam int DIST_W    = 7;
    localparam int GEN_W     = 8;
    localparam int STEP_W    = 7;

    // Stream widths
    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [GEN_W-1:0] GEN_MAX = 8'd255;
    localparam logic [GEN_W-1:0] GEN_ONE = 8'd1;

    // Command codes, carried in tuser
    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_INV_ROW = 2'd1,
        CMD_INV_COL = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    // Scan directions
    typedef enum logic [1:0] {
        DIR_EAST  = 2'd0,
        DIR_WEST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_NORTH = 2'd3
    } t_dir;

endpackage

FILE: rtl/jump_point_distance_cache.sv
`timescale 1ns / 1ps
// A cached query goes from the stamp lookup through ST_RESULT to the output register; a
// missed query runs the one-step-a-cycle scan (s = steps walked, up to 64) and then the
// one-write-a-cycle backfill of s cells into the single-port distance memory. A wrapping
// invalidate also clears that row's or column's entries for both of its directions.
// One transaction in flight at a time; a waiting result holds back only the next result.
// Reset: synchronous active low, then a clearing pass over all 16384 cells, tready low.
module jump_point_distance_cache (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [5:0] row, [11:6] col, [13:12] direction, [77:14] row_bits, [79:78] zero
    input  logic [jpdc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] cmd
    input  logic [jpdc_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [6:0] distance, [7] is_jump_point, [8] from_cache, [15:9] zero
    output logic [jpdc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import jpdc_pkg::*;

    typedef enum logic [9:0] {
        ST_INIT   = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_LOOK   = 10'b0000000100,
        ST_HLOAD  = 10'b0000001000,
        ST_VPRIME = 10'b0000010000,
        ST_HSCAN  = 10'b0000100000,
        ST_VSCAN  = 10'b0001000000,
        ST_FILL   = 10'b0010000000,
        ST_CLR    = 10'b0100000000,
        ST_RESULT = 10'b1000000000
    } t_state;

    localparam int CELLS_ALL = 1 << ADDR_W;

    // Out-of-grid columns count as blocked
    function automatic logic blk_bit(input logic [GRID_W-1:0] rowv,
                                     input logic signed [7:0] c);
        logic res;
        if (c < 8'sd0 || c > 8'sd63) begin
            res = 1'b1;
        end else begin
            res = rowv[c[POS_W-1:0]];
        end
        return res;
    endfunction

    // Memories
    logic [DIST_W+GEN_W-1:0] mem_dc  [CELLS_ALL];
    logic [GEN_W-1:0]        mem_rg  [GRID_H];
    logic [GEN_W-1:0]        mem_cg  [GRID_W];
    logic [GRID_W-1:0]       mem_obs [GRID_H];

    logic [GRID_H-1:0] r_rg_vld, r_obs_vld;
    logic [GRID_W-1:0] r_cg_vld;

    logic [DIST_W+GEN_W-1:0] r_dc_q;
    logic [GEN_W-1:0]        r_rg_q, r_cg_q;
    logic                    r_rg_v, r_cg_v;
    logic [GRID_W-1:0]       r_obs_q;
    logic                    r_obs_v, r_obs_oob;

    // Control and datapath registers
    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    t_dir               r_dir, n_dir;
    logic [POS_W-1:0]   r_y, n_y, r_x, n_x, r_fx, n_fx, r_fy, n_fy;
    logic [STEP_W-1:0]  r_s, n_s, r_k, n_k;
    logic               r_jump, n_jump, r_pl, n_pl, r_pr, n_pr;
    logic [GEN_W-1:0]   r_gen, n_gen;
    logic [GRID_W-1:0]  r_up, n_up, r_mid, n_mid, r_dn, n_dn;
    logic [DIST_W-1:0]  r_res_dist, n_res_dist;
    logic               r_res_jp, n_res_jp, r_res_fc, n_res_fc;
    logic               r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;
    logic [ADDR_W-1:0]  r_init_addr, n_init_addr;

    // Input fields
    logic               s_acc;
    t_cmd               in_cmd;
    logic [POS_W-1:0]   in_row, in_col;
    t_dir               in_dir;
    logic [GRID_W-1:0]  in_bits;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd  = t_cmd'(i_s_axis_tuser);
    assign in_row  = i_s_axis_tdata[5:0];
    assign in_col  = i_s_axis_tdata[11:6];
    assign in_dir  = t_dir'(i_s_axis_tdata[13:12]);
    assign in_bits = i_s_axis_tdata[77:14];

    // Derived datapath values
    logic                    horiz, neg, hit;
    logic [GEN_W-1:0]        rg, cg, q_gen;
    logic signed [7:0]       cx, px, xs, issue_off, issue_row;
    logic                    h_blk, h_force, v_blk, v_l, v_r, v_force, issue_oob;
    logic [GRID_W-1:0]       obs_row;
    logic [7:0]              fv;
    logic [DIST_W-1:0]       fdist;
    logic [POS_W-1:0]        obs_raddr;

    assign horiz = (r_dir == DIR_EAST) || (r_dir == DIR_WEST);
    assign neg   = (r_dir == DIR_WEST) || (r_dir == DIR_NORTH);
    assign rg    = r_rg_v ? r_rg_q : GEN_ONE;
    assign cg    = r_cg_v ? r_cg_q : GEN_ONE;
    assign q_gen = horiz ? rg : cg;
    assign hit   = (r_dc_q[GEN_W-1:0] == q_gen);

    // Horizontal step test against the three buffered rows
    assign xs = $signed({2'b00, r_x});
    assign cx = neg ? (xs - $signed({1'b0, r_s})) : (xs + $signed({1'b0, r_s}));
    assign px = neg ? (cx + 8'sd1) : (cx - 8'sd1);
    assign h_blk   = blk_bit(r_mid, cx);
    assign h_force = (!blk_bit(r_up, cx) && blk_bit(r_up, px)) ||
                     (!blk_bit(r_dn, cx) && blk_bit(r_dn, px));

    // Vertical step test on the row arriving from memory
    assign obs_row = r_obs_oob ? '1 : (r_obs_v ? r_obs_q : '0);
    assign v_blk   = blk_bit(obs_row, xs);
    assign v_l     = blk_bit(obs_row, xs - 8'sd1);
    assign v_r     = blk_bit(obs_row, xs + 8'sd1);
    assign v_force = (!v_l && r_pl) || (!v_r && r_pr);

    // Obstacle row to fetch this cycle
    always_comb begin
        case (r_state)
            ST_LOOK:   issue_off = horiz ? -8'sd1 : 8'sd0;
            ST_HLOAD:  issue_off = $signed({7'd0, r_k[0]});
            ST_VPRIME: issue_off = neg ? -$signed({1'b0, r_s}) : $signed({1'b0, r_s});
            ST_VSCAN:  issue_off = neg ? -$signed({1'b0, r_s + 7'd1})
                                       : $signed({1'b0, r_s + 7'd1});
            default:   issue_off = 8'sd0;
        endcase
    end
    assign issue_row = $signed({2'b00, r_y}) + issue_off;
    assign issue_oob = (issue_row < 8'sd0) || (issue_row > 8'sd63);
    assign obs_raddr = issue_row[POS_W-1:0];

    // Backfill value for step k of the run
    assign fv    = r_jump ? ({1'b0, r_s} - {1'b0, r_k})
                          : ({1'b0, r_k} - {1'b0, r_s} + 8'd1);
    assign fdist = fv[DIST_W-1:0];

    // Distance/stamp memory write port
    logic                    dc_we;
    logic [ADDR_W-1:0]       dc_waddr;
    logic [DIST_W+GEN_W-1:0] dc_wdata;

    always_comb begin
        dc_we    = 1'b0;
        dc_waddr = r_init_addr;
        dc_wdata = '0;
        case (r_state)
            ST_INIT: begin
                dc_we = 1'b1;
            end
            ST_CLR: begin
                dc_we = 1'b1;
                if (r_cmd == CMD_INV_ROW) begin
                    dc_waddr = {1'b0, r_k[6], r_y, r_k[5:0]};
                end else begin
                    dc_waddr = {1'b1, r_k[6], r_k[5:0], r_x};
                end
            end
            ST_FILL: begin
                dc_we    = 1'b1;
                dc_waddr = {r_dir, r_fy, r_fx};
                dc_wdata = {fdist, r_gen};
            end
            default: begin
                dc_we = 1'b0;
            end
        endcase
    end

    // Generation updates on invalidate
    logic             rg_we, cg_we;
    logic [GEN_W-1:0] rg_wdata, cg_wdata;

    assign rg_we    = (r_state == ST_LOOK) && (r_cmd == CMD_INV_ROW);
    assign cg_we    = (r_state == ST_LOOK) && (r_cmd == CMD_INV_COL);
    assign rg_wdata = (rg == GEN_MAX) ? GEN_ONE : rg + GEN_ONE;
    assign cg_wdata = (cg == GEN_MAX) ? GEN_ONE : cg + GEN_ONE;

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (dc_we) begin
            mem_dc[dc_waddr] <= dc_wdata;
        end
        if (s_acc) begin
            r_dc_q <= mem_dc[{in_dir, in_row, in_col}];
            r_rg_q <= mem_rg[in_row];
            r_rg_v <= r_rg_vld[in_row];
            r_cg_q <= mem_cg[in_col];
            r_cg_v <= r_cg_vld[in_col];
        end
        if (rg_we) begin
            mem_rg[r_y] <= rg_wdata;
        end
        if (cg_we) begin
            mem_cg[r_x] <= cg_wdata;
        end
        if (s_acc && in_cmd == CMD_WRITE) begin
            mem_obs[in_row] <= in_bits;
        end
        r_obs_q   <= mem_obs[obs_raddr];
        r_obs_v   <= r_obs_vld[obs_raddr];
        r_obs_oob <= issue_oob;
    end

    // Valid bits stand in for the reset values of the small stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rg_vld  <= '0;
            r_cg_vld  <= '0;
            r_obs_vld <= '0;
        end else begin
            if (rg_we) begin
                r_rg_vld[r_y] <= 1'b1;
            end
            if (cg_we) begin
                r_cg_vld[r_x] <= 1'b1;
            end
            if (s_acc && in_cmd == CMD_WRITE) begin
                r_obs_vld[in_row] <= 1'b1;
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_dir       = r_dir;
        n_y         = r_y;
        n_x         = r_x;
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_s         = r_s;
        n_k         = r_k;
        n_jump      = r_jump;
        n_pl        = r_pl;
        n_pr        = r_pr;
        n_gen       = r_gen;
        n_up        = r_up;
        n_mid       = r_mid;
        n_dn        = r_dn;
        n_res_dist  = r_res_dist;
        n_res_jp    = r_res_jp;
        n_res_fc    = r_res_fc;
        n_init_addr = r_init_addr;
        n_ovalid    = r_ovalid;
        n_odata     = r_odata;

        // output register drains independently
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_INIT: begin
                n_init_addr = r_init_addr + 1'b1;
                if (r_init_addr == ADDR_W'(CELLS_ALL - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc && in_cmd != CMD_WRITE) begin
                    n_cmd   = in_cmd;
                    n_dir   = in_dir;
                    n_y     = in_row;
                    n_x     = in_col;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                case (r_cmd)
                    CMD_INV_ROW: begin
                        n_k     = '0;
                        n_state = (rg == GEN_MAX) ? ST_CLR : ST_IDLE;
                    end
                    CMD_INV_COL: begin
                        n_k     = '0;
                        n_state = (cg == GEN_MAX) ? ST_CLR : ST_IDLE;
                    end
                    CMD_QUERY: begin
                        if (hit) begin
                            n_res_dist = r_dc_q[DIST_W+GEN_W-1:GEN_W];
                            n_res_jp   = !r_dc_q[DIST_W+GEN_W-1] &&
                                         (r_dc_q[DIST_W+GEN_W-1:GEN_W] != '0);
                            n_res_fc   = 1'b1;
                            n_state    = ST_RESULT;
                        end else begin
                            n_s     = STEP_W'(1);
                            n_k     = '0;
                            n_gen   = q_gen;
                            n_state = horiz ? ST_HLOAD : ST_VPRIME;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_HLOAD: begin
                // rows y-1, y, y+1 arrive one per cycle
                n_k = r_k + 1'b1;
                case (r_k[1:0])
                    2'd0:    n_up  = obs_row;
                    2'd1:    n_mid = obs_row;
                    default: begin
                        n_dn    = obs_row;
                        n_state = ST_HSCAN;
                    end
                endcase
            end
            ST_HSCAN: begin
                if (h_blk || h_force) begin
                    n_jump  = !h_blk;
                    n_k     = '0;
                    n_fx    = r_x;
                    n_fy    = r_y;
                    n_state = ST_FILL;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            ST_VPRIME: begin
                // side cells of the start cell
                n_pl    = v_l;
                n_pr    = v_r;
                n_state = ST_VSCAN;
            end
            ST_VSCAN: begin
                if (v_blk || v_force) begin
                    n_jump  = !v_blk;
                    n_k     = '0;
                    n_fx    = r_x;
                    n_fy    = r_y;
                    n_state = ST_FILL;
                end else begin
                    n_s  = r_s + 1'b1;
                    n_pl = v_l;
                    n_pr = v_r;
                end
            end
            ST_FILL: begin
                if (r_k == '0) begin
                    n_res_dist = fdist;
                    n_res_jp   = r_jump;
                    n_res_fc   = 1'b0;
                end
                n_k = r_k + 1'b1;
                case (r_dir)
                    DIR_EAST:  n_fx = r_fx + 1'b1;
                    DIR_WEST:  n_fx = r_fx - 1'b1;
                    DIR_SOUTH: n_fy = r_fy + 1'b1;
                    default:   n_fy = r_fy - 1'b1;
                endcase
                if (r_k == r_s - 1'b1) begin
                    n_state = ST_RESULT;
                end
            end
            ST_CLR: begin
                n_k = r_k + 1'b1;
                if (r_k == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {7'd0, r_res_fc, r_res_jp, r_res_dist};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init_addr <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_ovalid    <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_dir      <= n_dir;
        r_y        <= n_y;
        r_x        <= n_x;
        r_fx       <= n_fx;
        r_fy       <= n_fy;
        r_s        <= n_s;
        r_k        <= n_k;
        r_jump     <= n_jump;
        r_pl       <= n_pl;
        r_pr       <= n_pr;
        r_gen      <= n_gen;
        r_up       <= n_up;
        r_mid      <= n_mid;
        r_dn       <= n_dn;
        r_res_dist <= n_res_dist;
        r_res_jp   <= n_res_jp;
        r_res_fc   <= n_res_fc;
        r_odata    <= n_odata;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

FILE: rtl/jpdc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jpdc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [jpdc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [jpdc_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [jpdc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import jpdc_pkg::*;

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // only row writes leave the input side open
    `ASSERT_CLK(a_busy_after_cmd, i_clk, i_rst_n, s_acc && (i_s_axis_tuser != CMD_WRITE) |=> !o_s_axis_tready, "accepted a transaction while busy")

    // a query needs the store lookup before any result
    `ASSERT_CLK(a_no_instant_result, i_clk, i_rst_n, s_acc && (i_s_axis_tuser == CMD_QUERY) |=> !$rose(o_m_axis_tvalid), "result too early")

    // jump point flag implies a positive distance
    `ASSERT_NEVER(a_jp_sign, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[7] && (o_m_axis_tdata[6] || (o_m_axis_tdata[6:0] == 7'd0)), "jump point with non-positive distance")

endmodule

bind jump_point_distance_cache jpdc_checker u_jpdc_checker (.*);

FILE: tb/sv/tb_jump_point_distance_cache.sv
`timescale 1ns / 1ps

module tb_jump_point_distance_cache;
    import jpdc_pkg::*;

    typedef struct packed {
        logic signed [6:0] dval;
        logic              jump;
        logic              cached;
    } t_answer;

    typedef struct packed {
        t_cmd        cmd;
        logic [5:0]  row;
        logic [5:0]  col;
        t_dir        dir;
        logic [63:0] bits;
        logic        typed;
        t_answer     ans;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    jump_point_distance_cache u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Grid and cache mirror
    logic [63:0] grid_rows [64];
    logic [6:0]  cached_dist [4][64][64];
    logic [7:0]  cell_stamp [4][64][64];
    logic [7:0]  row_gen [64];
    logic [7:0]  col_gen [64];

    t_answer pending_answers[$];
    int      errors = 0;
    int      send_idle = 35;
    int      recv_idle = 62;
    int      hold_left = 0;

    function automatic logic is_blocked(int x, int y);
        if (x < 0 || x > 63 || y < 0 || y > 63) return 1'b1;
        return grid_rows[y][x];
    endfunction

    function automatic logic side_forced(int cx, int cy, int px, int py, int ox, int oy);
        return !is_blocked(cx + ox, cy + oy) && is_blocked(px + ox, py + oy);
    endfunction

    function automatic logic signed [6:0] sat_dist(int v);
        if (v > 63) return 7'sd63;
        if (v < -63) return -7'sd63;
        return v[6:0];
    endfunction

    // Applies one command to the mirror; returns 1 with the answer for queries
    function automatic logic apply_cmd(t_cmd cmd, int y, int x, t_dir dir,
                                       logic [63:0] bits, output t_answer ans);
        int dx, dy, s, k, d;
        logic horiz, jp;
        logic [7:0] g;
        dx = 0;
        dy = 0;
        d = int'(dir);
        ans = '0;
        case (cmd)
            CMD_WRITE: begin
                grid_rows[y] = bits;
                return 1'b0;
            end
            CMD_INV_ROW: begin
                if (row_gen[y] == GEN_MAX) begin
                    for (k = 0; k < 64; k++) begin
                        cell_stamp[DIR_EAST][y][k] = '0;
                        cell_stamp[DIR_WEST][y][k] = '0;
                    end
                    row_gen[y] = GEN_ONE;
                end else begin
                    row_gen[y]++;
                end
                return 1'b0;
            end
            CMD_INV_COL: begin
                if (col_gen[x] == GEN_MAX) begin
                    for (k = 0; k < 64; k++) begin
                        cell_stamp[DIR_SOUTH][k][x] = '0;
                        cell_stamp[DIR_NORTH][k][x] = '0;
                    end
                    col_gen[x] = GEN_ONE;
                end else begin
                    col_gen[x]++;
                end
                return 1'b0;
            end
            default: ;
        endcase
        case (dir)
            DIR_EAST:  dx = 1;
            DIR_WEST:  dx = -1;
            DIR_SOUTH: dy = 1;
            default:   dy = -1;
        endcase
        horiz = (dy == 0);
        g = horiz ? row_gen[y] : col_gen[x];
        if (cell_stamp[d][y][x] == g) begin
            ans.dval   = cached_dist[d][y][x];
            ans.jump   = ($signed(ans.dval) > 0);
            ans.cached = 1'b1;
            return 1'b1;
        end
        // walk until wall or forced neighbor
        jp = 1'b0;
        for (s = 1; ; s++) begin
            int cx, cy;
            cx = x + dx * s;
            cy = y + dy * s;
            if (is_blocked(cx, cy)) break;
            if (horiz)
                jp = side_forced(cx, cy, cx - dx, cy, 0, -1) ||
                     side_forced(cx, cy, cx - dx, cy, 0, 1);
            else
                jp = side_forced(cx, cy, cx, cy - dy, -1, 0) ||
                     side_forced(cx, cy, cx, cy - dy, 1, 0);
            if (jp) break;
        end
        // backfill the walked run
        for (k = 0; k < s; k++) begin
            cached_dist[d][y + dy * k][x + dx * k] = jp ? sat_dist(s - k) : sat_dist(k - s + 1);
            cell_stamp[d][y + dy * k][x + dx * k]  = g;
        end
        ans.dval   = jp ? sat_dist(s) : sat_dist(1 - s);
        ans.jump   = jp;
        ans.cached = 1'b0;
        return 1'b1;
    endfunction

    // Offer one transaction; valid stays high afterwards for back-to-back items
    task automatic send_item(t_cmd cmd, logic [5:0] y, logic [5:0] x, t_dir dir,
                             logic [63:0] bits, logic typed, t_answer typed_ans);
        t_answer ans;
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle) gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {2'b00, bits, dir, x, y};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (apply_cmd(cmd, y, x, dir, bits, ans))
            pending_answers.push_back(typed ? typed_ans : ans);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_bits();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: b = b & {$urandom, $urandom} & {$urandom, $urandom};
            1: b = b & {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            2: b = '0;
            default: ;
        endcase
        return b;
    endfunction

    // Result receiver with random stalls and a long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_m_axis_tdata);
                errors++;
            end else begin
                t_answer e;
                e = pending_answers.pop_front();
                if (o_m_axis_tdata[6:0] !== e.dval || o_m_axis_tdata[7] !== e.jump ||
                    o_m_axis_tdata[8] !== e.cached || o_m_axis_tdata[15:9] !== '0) begin
                    $display("%0t: mismatch, expected dist %0d jp %b cached %b, actual %0d %b %b",
                             $time, $signed(e.dval), e.jump, e.cached,
                             $signed(o_m_axis_tdata[6:0]), o_m_axis_tdata[7],
                             o_m_axis_tdata[8]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

    t_row directed [] = '{
        // empty grid: east from corner walks the whole row
        '{CMD_QUERY, 6'd0, 6'd0, DIR_EAST, 64'd0, 1'b1, '{-7'sd63, 1'b0, 1'b0}},
        '{CMD_QUERY, 6'd0, 6'd0, DIR_EAST, 64'd0, 1'b1, '{-7'sd63, 1'b0, 1'b1}},
        '{CMD_QUERY, 6'd0, 6'd63, DIR_EAST, 64'd0, 1'b1, '{7'sd0, 1'b0, 1'b1}},
        '{CMD_QUERY, 6'd63, 6'd0, DIR_SOUTH, 64'd0, 1'b1, '{7'sd0, 1'b0, 1'b0}},
        '{CMD_QUERY, 6'd0, 6'd0, DIR_NORTH, 64'd0, 1'b1, '{7'sd0, 1'b0, 1'b0}},
        '{CMD_QUERY, 6'd0, 6'd63, DIR_WEST, 64'd0, 1'b1, '{-7'sd63, 1'b0, 1'b0}},
        '{CMD_WRITE, 6'd10, 6'd0, DIR_EAST, '1, 1'b0, '0},
        // blocked cell above the path makes a forced neighbor one column later
        '{CMD_WRITE, 6'd20, 6'd0, DIR_EAST, 64'h20, 1'b0, '0},
        '{CMD_QUERY, 6'd21, 6'd0, DIR_EAST, 64'd0, 1'b1, '{7'sd6, 1'b1, 1'b0}},
        '{CMD_QUERY, 6'd21, 6'd0, DIR_EAST, 64'd0, 1'b1, '{7'sd6, 1'b1, 1'b1}},
        '{CMD_QUERY, 6'd21, 6'd3, DIR_EAST, 64'd0, 1'b1, '{7'sd3, 1'b1, 1'b1}},
        '{CMD_INV_ROW, 6'd21, 6'd0, DIR_EAST, 64'd0, 1'b0, '0},
        '{CMD_QUERY, 6'd21, 6'd3, DIR_EAST, 64'd0, 1'b1, '{7'sd3, 1'b1, 1'b0}},
        '{CMD_QUERY, 6'd15, 6'd4, DIR_NORTH, 64'd0, 1'b1, '{-7'sd4, 1'b0, 1'b0}},
        '{CMD_INV_COL, 6'd0, 6'd4, DIR_EAST, 64'd0, 1'b0, '0},
        '{CMD_QUERY, 6'd15, 6'd4, DIR_NORTH, 64'd0, 1'b1, '{-7'sd4, 1'b0, 1'b0}},
        '{CMD_WRITE, 6'd63, 6'd0, DIR_EAST, '1, 1'b0, '0},
        '{CMD_QUERY, 6'd62, 6'd0, DIR_SOUTH, 64'd0, 1'b1, '{7'sd0, 1'b0, 1'b0}},
        '{CMD_QUERY, 6'd62, 6'd5, DIR_EAST, 64'd0, 1'b1, '{-7'sd58, 1'b0, 1'b0}},
        '{CMD_QUERY, 6'd40, 6'd40, DIR_WEST, 64'd0, 1'b0, '0},
        '{CMD_QUERY, 6'd20, 6'd6, DIR_SOUTH, 64'd0, 1'b0, '0},
        '{CMD_WRITE, 6'd63, 6'd0, DIR_EAST, 64'd0, 1'b0, '0},
        '{CMD_QUERY, 6'd9, 6'd33, DIR_SOUTH, 64'd0, 1'b0, '0}
    };

    initial begin
        for (int i = 0; i < 64; i++) begin
            grid_rows[i] = '0;
            row_gen[i]   = GEN_ONE;
            col_gen[i]   = GEN_ONE;
            for (int d = 0; d < 4; d++)
                for (int j = 0; j < 64; j++) begin
                    cached_dist[d][i][j] = '0;
                    cell_stamp[d][i][j]  = '0;
                end
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed[i])
            send_item(directed[i].cmd, directed[i].row, directed[i].col, directed[i].dir,
                      directed[i].bits, directed[i].typed, directed[i].ans);

        // sender holds off until every answer is back
        wait_drained();

        // generation wrap on one row and one column, with queries across it
        for (int i = 0; i < 262; i++) begin
            send_item(CMD_INV_ROW, 6'd30, 6'd0, DIR_EAST, 64'd0, 1'b0, '0);
            send_item(CMD_INV_COL, 6'd0, 6'd9, DIR_EAST, 64'd0, 1'b0, '0);
            if (i % 16 == 0 || i > 250) begin
                send_item(CMD_QUERY, 6'd30, 6'($urandom_range(0, 63)),
                          t_dir'($urandom_range(0, 1)), 64'd0, 1'b0, '0);
                send_item(CMD_QUERY, 6'($urandom_range(0, 63)), 6'd9,
                          t_dir'($urandom_range(2, 3)), 64'd0, 1'b0, '0);
            end
        end

        // random traffic in three idling profiles
        for (int i = 0; i < 480; i++) begin
            t_cmd c;
            int r;
            if (i == 160) begin
                send_idle = 62;
                recv_idle = 35;
            end else if (i == 320) begin
                send_idle = 0;
                recv_idle = 0;
                hold_left = 600;
            end
            r = $urandom_range(0, 99);
            c = (r < 15) ? CMD_WRITE : (r < 23) ? CMD_INV_ROW :
                (r < 31) ? CMD_INV_COL : CMD_QUERY;
            send_item(c, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      t_dir'($urandom_range(0, 3)), rand_bits(), 1'b0, '0);
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: jump_point_distance_cache.f
+incdir+rtl
rtl/jpdc_pkg.sv
rtl/jump_point_distance_cache.sv
rtl/jpdc_checker.sv
tb/sv/tb_jump_point_distance_cache.sv
